// ----- rtl/nine_slice_coord_map_top_assert.svh -----
// Assertion macros used by the nine-slice coordinate map merge stage.
`ifndef NINE_SLICE_COORD_MAP_TOP_ASSERT_SVH
`define NINE_SLICE_COORD_MAP_TOP_ASSERT_SVH
// Consequent must hold in the same cycle as the antecedent.
`define NSCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define NSCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/nscm_pkg.sv -----
// Shared constants and register codes of the nine-slice coordinate map.
package nscm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OUT_W          = 22;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_LEFT       = 3'd4,
    REG_TOP        = 3'd5,
    REG_RIGHT      = 3'd6,
    REG_BOTTOM     = 3'd7
  } cfg_reg_e;

endpackage

// ----- rtl/nscm_if.sv -----
// Channel interfaces: configuration writes, coordinate requests, mapped results.
interface nscm_cfg_if #(
  parameter int COORD_BITS = nscm_pkg::COORD_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [nscm_pkg::CFG_IDX_W-1:0]     index;
  logic [COORD_BITS:0]                data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface nscm_in_if #(
  parameter int COORD_BITS = nscm_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] target_col;
  logic [COORD_BITS-1:0] target_row;

  modport source (output valid, target_col, target_row, input ready);
  modport sink (input valid, target_col, target_row, output ready);
endinterface

interface nscm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [nscm_pkg::OUT_W-1:0]  source_col;
  logic signed [nscm_pkg::OUT_W-1:0]  source_row;

  modport source (output valid, source_col, source_row, input ready);
  modport sink (input valid, source_col, source_row, output ready);
endinterface

// ----- rtl/nscm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module nscm_div #(
  parameter int NW = 39,
  parameter int DW = 16,
  parameter int QW = 22,
  parameter int TW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [TW-1:0] tag_q [QW];
  logic [QW-1:0] v_q;

  logic [DW-1:0] rem_p [QW];
  logic [QW-1:0] low_p [QW];
  logic [QW-1:0] quo_p [QW];
  logic [DW-1:0] den_p [QW];
  logic [TW-1:0] tag_p [QW];
  logic [QW-1:0] v_p;

  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] low_d [QW];
  logic [QW-1:0] quo_d [QW];

  // stage inputs: the request for stage 0, the previous stage otherwise
  always_comb begin
    rem_p[0] = num_i[QW +: DW];
    low_p[0] = num_i[QW-1:0];
    quo_p[0] = '0;
    den_p[0] = den_i;
    tag_p[0] = tag_i;
    v_p[0]   = valid_i;
    for (int k = 1; k < QW; k++) begin
      rem_p[k] = rem_q[k-1];
      low_p[k] = low_q[k-1];
      quo_p[k] = quo_q[k-1];
      den_p[k] = den_q[k-1];
      tag_p[k] = tag_q[k-1];
      v_p[k]   = v_q[k-1];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    for (int k = 0; k < QW; k++) begin
      trial    = {rem_p[k], low_p[k][QW-1]};
      diff     = trial - {1'b0, den_p[k]};
      ge       = (trial >= {1'b0, den_p[k]});
      rem_d[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
      low_d[k] = {low_p[k][QW-2:0], 1'b0};
      quo_d[k] = {quo_p[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_p;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_p[k];
        tag_q[k] <= tag_p[k];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ----- rtl/nscm_lane.sv -----
// One axis lane: border classification, middle scaling and rounding.
module nscm_lane #(
  parameter int COORD_BITS = nscm_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = nscm_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [COORD_BITS-1:0]                 coord_i,
  input  logic [COORD_BITS-1:0]                 src_size_i,
  input  logic [COORD_BITS-1:0]                 dst_size_i,
  input  logic [COORD_BITS:0]                   lead_reg_i,
  input  logic [COORD_BITS:0]                   trail_reg_i,
  output logic                                  valid_o,
  output logic signed [COORD_BITS+FRAC_BITS+3:0] result_o
);

  localparam int SW = COORD_BITS + 4;             // half-pixel signed width
  localparam int AW = COORD_BITS + 3;             // multiplier operand width
  localparam int DW = AW + 1;                     // divisor width
  localparam int QW = COORD_BITS + FRAC_BITS + 2; // quotient width
  localparam int NW = 2 * AW + FRAC_BITS + 1;     // dividend width
  localparam int RW = COORD_BITS + FRAC_BITS + 4; // result width before clamp
  localparam int TW = RW + 1;

  // ---------------------------------------------------------------------------
  // Setup terms derived from the configuration, two register levels
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] src2, dst2, src1, lead_b, trail_b;
  logic signed [SW-1:0] lead_d, lead_q, trail_d, trail_q;
  logic signed [SW-1:0] lim_d, lim_q, dm_d, dm_q, sm_d, sm_q;
  logic                 mid_ok_d, mid_ok_q;
  logic signed [RW-1:0] lead_f, h_d, h_q;
  logic                 r_d, r_q;

  assign src2    = $signed({{(SW-COORD_BITS-1){1'b0}}, src_size_i, 1'b0});
  assign dst2    = $signed({{(SW-COORD_BITS-1){1'b0}}, dst_size_i, 1'b0});
  assign src1    = $signed({{(SW-COORD_BITS){1'b0}}, src_size_i});
  assign lead_b  = $signed({{(SW-COORD_BITS-2){lead_reg_i[COORD_BITS]}}, lead_reg_i, 1'b0});
  assign trail_b = $signed({{(SW-COORD_BITS-2){trail_reg_i[COORD_BITS]}}, trail_reg_i, 1'b0});

  // a negative border counts from half the source size
  assign lead_d  = lead_reg_i[COORD_BITS] ? lead_b + src1 : lead_b;
  assign trail_d = trail_reg_i[COORD_BITS] ? trail_b + src1 : trail_b;

  assign lim_d    = dst2 - trail_q;
  assign dm_d     = dst2 - lead_q - trail_q;
  assign sm_d     = src2 - lead_q - trail_q;
  assign mid_ok_d = !dm_d[SW-1] && (dm_d != '0) && !sm_d[SW-1] && (sm_d != '0);
  // lead * 2^FRAC split as 2*h + r
  assign lead_f   = RW'(lead_q) <<< FRAC_BITS;
  assign h_d      = lead_f >>> 1;
  assign r_d      = lead_f[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= '0;
      trail_q  <= '0;
      lim_q    <= '0;
      dm_q     <= '0;
      sm_q     <= '0;
      mid_ok_q <= 1'b0;
      h_q      <= '0;
      r_q      <= 1'b0;
    end else begin
      lead_q   <= lead_d;
      trail_q  <= trail_d;
      lim_q    <= lim_d;
      dm_q     <= dm_d;
      sm_q     <= sm_d;
      mid_ok_q <= mid_ok_d;
      h_q      <= h_d;
      r_q      <= r_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Request pipeline
  // ---------------------------------------------------------------------------
  logic                  v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [COORD_BITS-1:0] t0_q;

  // stage 1: leading border test and border results
  logic signed [SW-1:0] t2_0, a_d, a_q, t2_q;
  logic signed [RW-1:0] tw, srcw, dstw, val_lead, val_trail, val_d, val_q;
  logic                 lt_lead_d, lt_lead_q;

  assign t2_0      = $signed({{(SW-COORD_BITS-1){1'b0}}, t0_q, 1'b0});
  assign lt_lead_d = t2_0 < lead_q;
  assign a_d       = t2_0 - lead_q;
  assign tw        = $signed({{(RW-COORD_BITS){1'b0}}, t0_q});
  assign srcw      = $signed({{(RW-COORD_BITS){1'b0}}, src_size_i});
  assign dstw      = $signed({{(RW-COORD_BITS){1'b0}}, dst_size_i});
  assign val_lead  = tw <<< FRAC_BITS;
  assign val_trail = (tw - dstw + srcw) <<< FRAC_BITS;
  assign val_d     = lt_lead_d ? val_lead : val_trail;

  // stage 2: region select
  logic                 lt_lim, in_mid, mid_go_d, mid2_q;
  logic signed [RW-1:0] base2_d, base2_q;
  logic [AW-1:0]        a2_d, a2_q, sm2_q, dm2_q;
  logic                 r2_q;

  assign lt_lim   = t2_q < lim_q;
  assign in_mid   = !lt_lead_q && lt_lim;
  assign mid_go_d = in_mid && mid_ok_q;
  assign base2_d  = !in_mid   ? val_q :
                    mid_ok_q  ? h_q   : h_q + $signed({{(RW-1){1'b0}}, r_q});
  assign a2_d     = mid_go_d ? a_q[AW-1:0] : '0;

  // stage 3: product, stage 4: dividend and divisor
  logic [2*AW-1:0]      prod_q;
  logic [AW-1:0]        dm3_q;
  logic                 r3_q, mid3_q;
  logic signed [RW-1:0] base3_q;
  logic [NW-1:0]        num_d, num_q;
  logic [DW-1:0]        den_q;
  logic [TW-1:0]        tag_q;

  assign num_d = (NW'(prod_q) << FRAC_BITS) +
                 (r3_q ? NW'({dm3_q, 1'b0}) : NW'(dm3_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q      <= coord_i;
      t2_q      <= t2_0;
      lt_lead_q <= lt_lead_d;
      a_q       <= a_d;
      val_q     <= val_d;
      mid2_q    <= mid_go_d;
      base2_q   <= base2_d;
      a2_q      <= a2_d;
      sm2_q     <= sm_q[AW-1:0];
      dm2_q     <= dm_q[AW-1:0];
      r2_q      <= r_q;
      prod_q    <= (2*AW)'(a2_q) * (2*AW)'(sm2_q);
      dm3_q     <= dm2_q;
      r3_q      <= r2_q;
      mid3_q    <= mid2_q;
      base3_q   <= base2_q;
      num_q     <= num_d;
      den_q     <= {dm3_q, 1'b0};
      tag_q     <= {mid3_q, base3_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Division and final offset
  // ---------------------------------------------------------------------------
  logic          div_v;
  logic [QW-1:0] div_quo;
  logic [TW-1:0] div_tag;
  logic signed [RW-1:0] div_base, res_d, res_q;

  nscm_div #(
    .NW (NW),
    .DW (DW),
    .QW (QW),
    .TW (TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v4_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .tag_i   (tag_q),
    .valid_o (div_v),
    .quo_o   (div_quo),
    .tag_o   (div_tag)
  );

  assign div_base = $signed(div_tag[RW-1:0]);
  assign res_d    = div_tag[TW-1] ? div_base + $signed({{(RW-QW){1'b0}}, div_quo})
                                  : div_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = v5_q;
  assign result_o = res_q;

endmodule

// ----- rtl/nscm_merge.sv -----
// Merge stage: clamps both lane results and holds them in an output skid buffer.
module nscm_merge #(
  parameter int RW = nscm_pkg::COORD_BITS_DEF + nscm_pkg::FRAC_BITS_DEF + 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 col_valid_i,
  input  logic                 row_valid_i,
  input  logic signed [RW-1:0] col_res_i,
  input  logic signed [RW-1:0] row_res_i,
  output logic                 ready_o,
  nscm_out_if.source           rsp_o
);

  import nscm_pkg::*;

  localparam int EW = (RW > OUT_W) ? RW : OUT_W;

  function automatic logic signed [OUT_W-1:0] clamp(input logic signed [RW-1:0] v);
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    e  = EW'(v);
    hi = $signed({{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
    lo = -hi - $signed(EW'(1));
    if (e > hi) begin
      return OUT_W'(hi);
    end else if (e < lo) begin
      return OUT_W'(lo);
    end
    return OUT_W'(e);
  endfunction

  logic                    out_v_q, sk_v_q, push;
  logic signed [OUT_W-1:0] col_c, row_c;
  logic signed [OUT_W-1:0] out_col_q, out_row_q, sk_col_q, sk_row_q;

  assign col_c   = clamp(col_res_i);
  assign row_c   = clamp(row_res_i);
  assign ready_o = !sk_v_q;
  assign push    = col_valid_i && !sk_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (!out_v_q || rsp_o.ready) begin
      out_v_q <= sk_v_q || push;
      sk_v_q  <= 1'b0;
    end else if (push) begin
      sk_v_q  <= 1'b1;
    end
  end

  // drain the skid entry first; park a new result there while the output stalls
  always_ff @(posedge clk_i) begin
    if (!out_v_q || rsp_o.ready) begin
      if (sk_v_q) begin
        out_col_q <= sk_col_q;
        out_row_q <= sk_row_q;
      end else if (push) begin
        out_col_q <= col_c;
        out_row_q <= row_c;
      end
    end else if (push) begin
      sk_col_q <= col_c;
      sk_row_q <= row_c;
    end
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.source_col = out_col_q;
  assign rsp_o.source_row = out_row_q;

`include "nine_slice_coord_map_top_assert.svh"

  `NSCM_ASSERT_NOW(a_lanes_in_step, 1'b1, col_valid_i == row_valid_i, "lanes out of step")
  `NSCM_ASSERT_NOW(a_skid_needs_out, sk_v_q, out_v_q, "skid full with empty output")
  `NSCM_ASSERT_NOW(a_skid_on_stall, $rose(sk_v_q), $past(out_v_q && !rsp_o.ready), "skid filled without stall")
  `NSCM_ASSERT_NEXT(a_stall_push_kept, push && out_v_q && !rsp_o.ready, sk_v_q, "result lost on stall")

endmodule

// ----- rtl/nine_slice_coord_map_top.sv -----
// Nine-slice inverse coordinate map: column and row lanes, config registers, output skid.
// Throughput: one request per cycle while the output skid entry is free;
// the rate is set by the per-bit pipelined divider in each lane.
// Reset: async active low; config registers clear to zero, pipeline and output empty.
module nine_slice_coord_map_top #(
  parameter int COORD_BITS = nscm_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = nscm_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nscm_cfg_if.sink   cfg_i,
  nscm_in_if.sink    req_i,
  nscm_out_if.source rsp_o
);

  import nscm_pkg::*;

  localparam int RW = COORD_BITS + FRAC_BITS + 4;

  logic [COORD_BITS-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [COORD_BITS:0]   left_q, top_q, right_q, bottom_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= '0;
      src_h_q  <= '0;
      dst_w_q  <= '0;
      dst_h_q  <= '0;
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_SRC_WIDTH:  src_w_q  <= cfg_i.data[COORD_BITS-1:0];
        REG_SRC_HEIGHT: src_h_q  <= cfg_i.data[COORD_BITS-1:0];
        REG_DST_WIDTH:  dst_w_q  <= cfg_i.data[COORD_BITS-1:0];
        REG_DST_HEIGHT: dst_h_q  <= cfg_i.data[COORD_BITS-1:0];
        REG_LEFT:       left_q   <= cfg_i.data;
        REG_TOP:        top_q    <= cfg_i.data;
        REG_RIGHT:      right_q  <= cfg_i.data;
        REG_BOTTOM:     bottom_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic                 en;
  logic                 col_v, row_v;
  logic signed [RW-1:0] col_res, row_res;

  // the whole pipeline advances together while the skid entry is free
  assign req_i.ready = en;

  nscm_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_col (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (req_i.valid),
    .coord_i     (req_i.target_col),
    .src_size_i  (src_w_q),
    .dst_size_i  (dst_w_q),
    .lead_reg_i  (left_q),
    .trail_reg_i (right_q),
    .valid_o     (col_v),
    .result_o    (col_res)
  );

  nscm_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (req_i.valid),
    .coord_i     (req_i.target_row),
    .src_size_i  (src_h_q),
    .dst_size_i  (dst_h_q),
    .lead_reg_i  (top_q),
    .trail_reg_i (bottom_q),
    .valid_o     (row_v),
    .result_o    (row_res)
  );

  nscm_merge #(
    .RW (RW)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_valid_i (col_v),
    .row_valid_i (row_v),
    .col_res_i   (col_res),
    .row_res_i   (row_res),
    .ready_o     (en),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- sim/nscm_map_checker.sv -----
// Checker for the nine-slice coordinate map: shadows the registers, predicts and compares results.
`timescale 1ns / 100ps

module nscm_map_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  nscm_cfg_if         cfg_i,
  nscm_in_if          req_i,
  nscm_out_if         rsp_i,
  output int unsigned mismatches_o,
  output int unsigned in_flight_o,
  output int unsigned results_checked_o
);
  import nscm_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [OUT_W-1:0] col;
    logic signed [OUT_W-1:0] row;
  } src_pos_t;

  src_pos_t      src_pos_q[$];
  logic [CW-1:0] src_w, src_h, dst_w, dst_h;
  logic [CW:0]   left_b, top_b, right_b, bottom_b;

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Round n/d to nearest, ties toward plus infinity; d > 0.
  function automatic longint nearest_quot(longint n, longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  // Border in half pixels; a negative border counts from half the source size.
  function automatic longint half_px_border(logic [CW:0] raw, logic [CW-1:0] src);
    logic signed [CW:0] sv;
    longint b;
    sv = raw;
    b = longint'(sv);
    b = 2 * b;
    if (b < 0) b = b + longint'(src);
    return b;
  endfunction

  function automatic logic signed [OUT_W-1:0] inverse_map_axis(
      logic [CW-1:0] t, logic [CW-1:0] src, logic [CW-1:0] dst,
      logic [CW:0] lead_raw, logic [CW:0] trail_raw);
    longint one, t2, s2, d2, lead, trail, tot, dm, num, v, hi, lo;
    one   = longint'(1) << FW;
    t2    = 2 * longint'(t);
    s2    = 2 * longint'(src);
    d2    = 2 * longint'(dst);
    lead  = half_px_border(lead_raw, src);
    trail = half_px_border(trail_raw, src);
    tot   = lead + trail;
    if (t2 < lead) begin
      v = (t2 / 2) * one;
    end else if (t2 < d2 - trail) begin
      if (d2 > tot && s2 > tot) begin
        dm  = d2 - tot;
        num = (lead * dm + (t2 - lead) * (s2 - tot)) * one;
        v   = nearest_quot(num, 2 * dm);
      end else begin
        // no room for a middle on one side: pin to the leading border
        v = nearest_quot(lead * one, 2);
      end
    end else begin
      v = ((t2 - d2 + s2) / 2) * one;
    end
    hi = (longint'(1) << (OUT_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    src_pos_t want;
    if (!rst_ni) begin
      src_w = '0;
      src_h = '0;
      dst_w = '0;
      dst_h = '0;
      left_b = '0;
      top_b = '0;
      right_b = '0;
      bottom_b = '0;
      src_pos_q.delete();
      mismatches_o = 0;
      results_checked_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_SRC_WIDTH:  src_w = cfg_i.data[CW-1:0];
          REG_SRC_HEIGHT: src_h = cfg_i.data[CW-1:0];
          REG_DST_WIDTH:  dst_w = cfg_i.data[CW-1:0];
          REG_DST_HEIGHT: dst_h = cfg_i.data[CW-1:0];
          REG_LEFT:       left_b = cfg_i.data;
          REG_TOP:        top_b = cfg_i.data;
          REG_RIGHT:      right_b = cfg_i.data;
          REG_BOTTOM:     bottom_b = cfg_i.data;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        want.col = inverse_map_axis(req_i.target_col, src_w, dst_w, left_b, right_b);
        want.row = inverse_map_axis(req_i.target_row, src_h, dst_h, top_b, bottom_b);
        src_pos_q.push_back(want);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        results_checked_o++;
        if (src_pos_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result (%0d, %0d) with no request outstanding",
                     $realtime, rsp_i.source_col, rsp_i.source_row);
        end else begin
          want = src_pos_q.pop_front();
          if (rsp_i.source_col !== want.col || rsp_i.source_row !== want.row) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: source_col exp %0d got %0d, source_row exp %0d got %0d",
                       $realtime, want.col, rsp_i.source_col, want.row, rsp_i.source_row);
          end
        end
      end
    end
    in_flight_o = src_pos_q.size();
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the nine-slice coordinate map: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb;
  import nscm_pkg::*;

  localparam int CW              = COORD_BITS_DEF;
  localparam int LATENCY         = COORD_BITS_DEF + FRAC_BITS_DEF + 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 78;

  typedef enum {CFG_WILD, CFG_EXTREME, CFG_SCALER} cfg_style_e;

  logic clk_i;
  logic rst_ni;

  nscm_cfg_if cfg_ch ();
  nscm_in_if  req_ch ();
  nscm_out_if rsp_ch ();

  int unsigned mismatches, in_flight, results_checked;
  int unsigned idle_cycles = 0;
  int unsigned requests_sent = 0;
  int unsigned settings_used = 0;
  bit          tx_no_gap = 1'b0;
  bit          rx_no_stall = 1'b0;
  logic [CW:0] reg_val [8];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  nine_slice_coord_map_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  nscm_map_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_ch),
    .req_i             (req_ch),
    .rsp_i             (rsp_ch),
    .mismatches_o      (mismatches),
    .in_flight_o       (in_flight),
    .results_checked_o (results_checked)
  );

  always @(posedge clk_i) begin
    if ((cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready) ||
        (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Timeout: no transfer on any channel for %0d cycles", STALL_LIMIT);
        $display("[nine_slice_coord_map_top] ERROR");
        $finish;
      end
    end
  end

  // Result side: unless rx_no_stall is set, stall a random number of cycles before taking each result.
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = rx_no_stall ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_ch.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  // Leave valid high on return so a back-to-back request keeps it up.
  task automatic send_coord(input logic [CW-1:0] col, input logic [CW-1:0] row);
    int unsigned gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.target_col <= col;
    req_ch.target_row <= row;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    @(negedge clk_i);
    requests_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CW:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic program_regs();
    cfg_reg_e r;
    r = r.first();
    repeat (r.num()) begin
      write_reg(r, reg_val[r]);
      r = r.next();
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic apply_settings(input logic [CW:0] v [8]);
    reg_val = v;
    program_regs();
  endtask

  // Drop valid, wait for every result, then let the pipeline run dry.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic pick_settings(input cfg_style_e style);
    cfg_reg_e    r;
    int unsigned k, s;
    r = r.first();
    repeat (r.num()) begin
      k = $urandom_range(0, 3);
      case (style)
        CFG_WILD: reg_val[r] = (CW + 1)'($urandom_range(0, 8191));
        CFG_EXTREME: begin
          if (r <= REG_DST_HEIGHT)
            reg_val[r] = (k == 0) ? 13'd0 : (k == 1) ? 13'd1 : (k == 2) ? 13'd4095 : 13'h1FFF;
          else
            reg_val[r] = (k == 0) ? 13'd0 : (k == 1) ? 13'd4095 : (k == 2) ? 13'h1000 : 13'h1FFF;
        end
        default: begin
          if (r == REG_SRC_WIDTH || r == REG_SRC_HEIGHT) begin
            reg_val[r] = (CW + 1)'($urandom_range(1, 600));
          end else if (r == REG_DST_WIDTH || r == REG_DST_HEIGHT) begin
            reg_val[r] = (CW + 1)'($urandom_range(1, 1200));
          end else begin
            s = (r == REG_LEFT || r == REG_RIGHT) ? 32'(reg_val[REG_SRC_WIDTH])
                                                  : 32'(reg_val[REG_SRC_HEIGHT]);
            // some borders measured back from the source center
            if (k == 0) reg_val[r] = (CW + 1)'(-int'($urandom_range(1, s / 2 + 1)));
            else        reg_val[r] = (CW + 1)'($urandom_range(0, s / 3));
          end
        end
      endcase
      r = r.next();
    end
  endtask

  // Mostly stay on or just past the destination area; sometimes go anywhere.
  function automatic logic [CW-1:0] pick_coord(input logic [CW:0] dst_raw);
    int unsigned hi;
    hi = 32'(dst_raw[CW-1:0]) + 2;
    if (hi > 4095) hi = 4095;
    if ($urandom_range(0, 99) < 85) return CW'($urandom_range(0, hi));
    return CW'($urandom());
  endfunction

  initial begin
    cfg_style_e style;
    int unsigned pick;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_SRC_WIDTH;
    cfg_ch.data       = '0;
    req_ch.valid      = 1'b0;
    req_ch.target_col = '0;
    req_ch.target_row = '0;
    rst_ni            = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset: every coordinate lands in the trailing border
    send_coord(12'd0, 12'd0);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'h5A5, 12'hA5A);
    drain();

    // ordinary stretch, bottom border taken from the source center
    apply_settings('{13'd64, 13'd48, 13'd200, 13'd150, 13'd8, 13'd6, 13'd8, -13'sd4});
    send_coord(12'd0, 12'd0);
    send_coord(12'd7, 12'd5);
    send_coord(12'd8, 12'd6);
    send_coord(12'd100, 12'd75);
    send_coord(12'd191, 12'd129);
    send_coord(12'd192, 12'd130);
    send_coord(12'd199, 12'd149);
    send_coord(12'd4095, 12'd4095);
    drain();

    // half-pixel leading border, most negative trailing border
    apply_settings('{13'd33, 13'd1, 13'd20, 13'd4095, -13'sd1, 13'd0, 13'h1000, 13'd4095});
    send_coord(12'd15, 12'd0);
    send_coord(12'd16, 12'd1);
    send_coord(12'd4095, 12'd2048);
    drain();

    // column borders wider than the source: the column middle collapses onto the leading border
    apply_settings('{13'd10, 13'd4095, 13'd30, 13'd5, 13'd6, 13'd2, 13'd6, 13'd2});
    send_coord(12'd3, 12'd1);
    send_coord(12'd12, 12'd2);
    send_coord(12'd29, 12'd4);
    send_coord(12'd0, 12'd3);
    drain();

    // ends of every range (most negative top and right borders); size writes also set the unused upper data bit
    apply_settings('{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF,
                     13'd4095, 13'h1000, 13'h1000, 13'd4095});
    send_coord(12'd0, 12'd4095);
    send_coord(12'd4095, 12'd0);
    send_coord(12'd2048, 12'd2047);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick = $urandom_range(0, 5);
      if (p == 0)         style = CFG_EXTREME;
      else if (p == 1)    style = CFG_WILD;
      else if (pick == 0) style = CFG_WILD;
      else if (pick == 1) style = CFG_EXTREME;
      else                style = CFG_SCALER;
      pick_settings(style);
      program_regs();
      tx_no_gap   = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE)
        send_coord(pick_coord(reg_val[REG_DST_WIDTH]), pick_coord(reg_val[REG_DST_HEIGHT]));
      drain();
    end

    $display("Ran %0d register settings and %0d coordinate requests; %0d results compared.",
             settings_used, requests_sent, results_checked);
    $display("Mismatching results: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[nine_slice_coord_map_top] OK");
    end else begin
      $display("[nine_slice_coord_map_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nscm_pkg.sv
rtl/nscm_if.sv
rtl/nscm_div.sv
rtl/nscm_lane.sv
rtl/nscm_merge.sv
rtl/nine_slice_coord_map_top.sv
sim/nscm_map_checker.sv
sim/tb.sv
